// ===== rtl/mmn_pkg.sv =====
package mmn_pkg;

  // column store depth and index width
  localparam int unsigned MAX_ATTRS = 16;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned ADDR_W    = (MAX_ATTRS > 1) ? $clog2(MAX_ATTRS) : 1;

  // sample and result formats
  localparam int unsigned VAL_W   = 24;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned SCALE_W = FRAC_W + 1;
  localparam int unsigned CNT_W   = $clog2(FRAC_W);

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [IDX_W-1:0]        index_t;
  typedef logic [SCALE_W-1:0]      scaled_t;

  localparam value_t  VAL_MAX_Q = value_t'({1'b0, {(VAL_W-1){1'b1}}});
  localparam value_t  VAL_MIN_Q = value_t'({1'b1, {(VAL_W-1){1'b0}}});
  localparam scaled_t ONE_Q16   = scaled_t'({1'b1, {FRAC_W{1'b0}}});

  // request function codes
  localparam logic FUNC_MEASURE = 1'b0;
  localparam logic FUNC_SCALE   = 1'b1;

  typedef struct packed {
    value_t col_min;
    value_t col_max;
  } entry_t;

endpackage

// ===== rtl/mmn_req_if.sv =====
interface mmn_req_if import mmn_pkg::*; ;
  logic   valid;
  logic   ready;
  logic   func;
  index_t attr_index;
  value_t sample_value;
  logic   first_row;

  modport source (output valid, func, attr_index, sample_value, first_row, input ready);
  modport sink   (input valid, func, attr_index, sample_value, first_row, output ready);
endinterface

// ===== rtl/mmn_rsp_if.sv =====
interface mmn_rsp_if import mmn_pkg::*; ;
  logic    valid;
  logic    ready;
  scaled_t scaled_value;
  index_t  attr_index_out;

  modport source (output valid, scaled_value, attr_index_out, input ready);
  modport sink   (input valid, scaled_value, attr_index_out, output ready);
endinterface

// ===== rtl/minmax_feature_normalizer.sv =====
// min-max feature normalizer
// req_i carries one request: func selects measure or scale, attr_index picks
// the column, sample_value is signed Q15.8, first_row restarts a column on a
// measure request. a measure request updates the column's running min and
// max and gives no response. a scale request gives one response on rsp_o:
// (value - min) / (max - min) in unsigned Q1.16, clamped to 0 .. 65536, and
// 0 for a constant or unmeasured column, with the column index echoed.
// min and max live in one 16-entry synchronous ram, read as the request is
// taken, with the data ready in the cycle after. a measure request reads
// the column, then writes it back. a clamped scale request skips the divider;
// any other runs the 16-step restoring divider, one quotient bit a cycle.
// one request is in flight at a time; req_i.ready is high only while idle.
// the response sits in an output register, so the next request is taken
// while it waits; if the receiver stalls with a second result ready, the
// block holds that result and takes no request until the register frees.
// reset clears per-column valid flops, so every column reads as unmeasured
// (min = largest positive, max = most negative) with no clearing pass.
module minmax_feature_normalizer import mmn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  mmn_req_if.sink   req_i,
  mmn_rsp_if.source rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e state_q;

  // request capture
  logic              func_q;
  logic              first_q;
  logic              idx_ok_q;
  index_t            idx_q;
  logic [ADDR_W-1:0] addr_q;
  value_t            val_q;

  // column ram and per-entry valid bits
  entry_t            mem_q [MAX_ATTRS];
  entry_t            rd_data_q;
  logic              rd_vld_q;
  logic [MAX_ATTRS-1:0] vld_q;

  // divider
  logic [VAL_W-1:0]  rem_q;
  logic [VAL_W-1:0]  den_q;
  logic [FRAC_W-1:0] quo_q;
  logic [CNT_W-1:0]  cnt_q;
  scaled_t           res_q;

  // output register
  logic              out_vld_q;
  scaled_t           out_val_q;
  index_t            out_idx_q;

  logic              req_acc;
  logic              out_free;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  entry_t            wr_data;

  value_t            cur_min;
  value_t            cur_max;
  value_t            new_min;
  value_t            new_max;
  logic signed [VAL_W:0] num;
  logic signed [VAL_W:0] den;
  logic [VAL_W:0]    rem_sh;
  logic              q_bit;
  logic [VAL_W-1:0]  rem_nxt;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign rd_addr     = req_i.attr_index[ADDR_W-1:0];
  assign out_free    = !out_vld_q || rsp_o.ready;

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.scaled_value   = out_val_q;
  assign rsp_o.attr_index_out = out_idx_q;

  // unmeasured columns read as their reset extremes
  assign cur_min = rd_vld_q ? rd_data_q.col_min : VAL_MAX_Q;
  assign cur_max = rd_vld_q ? rd_data_q.col_max : VAL_MIN_Q;

  always_comb begin
    if (first_q) begin
      new_min = val_q;
      new_max = val_q;
    end else begin
      new_min = (val_q < cur_min) ? val_q : cur_min;
      new_max = (val_q > cur_max) ? val_q : cur_max;
    end
  end

  assign num = {val_q[VAL_W-1], val_q} - {cur_min[VAL_W-1], cur_min};
  assign den = {cur_max[VAL_W-1], cur_max} - {cur_min[VAL_W-1], cur_min};

  // one restoring step: remainder stays below den
  assign rem_sh  = {rem_q, 1'b0};
  assign q_bit   = (rem_sh >= {1'b0, den_q});
  assign rem_nxt = q_bit ? VAL_W'(rem_sh - {1'b0, den_q}) : rem_sh[VAL_W-1:0];

  assign mem_we  = (state_q == ST_EXEC) && (func_q == FUNC_MEASURE) && idx_ok_q;
  assign wr_data = '{col_min: new_min, col_max: new_max};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr_q] <= wr_data;
    end
    if (req_acc) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      func_q    <= FUNC_MEASURE;
      first_q   <= 1'b0;
      idx_ok_q  <= 1'b0;
      idx_q     <= '0;
      addr_q    <= '0;
      val_q     <= '0;
      rem_q     <= '0;
      den_q     <= '0;
      quo_q     <= '0;
      cnt_q     <= '0;
      res_q     <= '0;
      out_val_q <= '0;
      out_idx_q <= '0;
    end else begin
      // load a new response or retire the waiting one
      if ((state_q == ST_OUT) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_acc) begin
            func_q   <= req_i.func;
            first_q  <= req_i.first_row;
            idx_q    <= req_i.attr_index;
            idx_ok_q <= (int'(req_i.attr_index) < MAX_ATTRS);
            addr_q   <= rd_addr;
            val_q    <= req_i.sample_value;
            rd_vld_q <= vld_q[rd_addr];
            state_q  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          // sign bit set means negative
          if (func_q == FUNC_MEASURE) begin
            if (idx_ok_q) begin
              vld_q[addr_q] <= 1'b1;
            end
            state_q <= ST_IDLE;
          end else if (!idx_ok_q || den[VAL_W] || (den == '0) ||
                       num[VAL_W] || (num == '0)) begin
            res_q   <= '0;
            state_q <= ST_OUT;
          end else if (num >= den) begin
            res_q   <= ONE_Q16;
            state_q <= ST_OUT;
          end else begin
            rem_q   <= num[VAL_W-1:0];
            den_q   <= den[VAL_W-1:0];
            quo_q   <= '0;
            cnt_q   <= CNT_W'(FRAC_W - 1);
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q <= rem_nxt;
          quo_q <= {quo_q[FRAC_W-2:0], q_bit};
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            res_q   <= {1'b0, quo_q[FRAC_W-2:0], q_bit};
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_val_q <= res_q;
            out_idx_q <= idx_q;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a pending response never exceeds 1.0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_val_q <= ONE_Q16))
    else $error("scaled value above 1.0");

  // restoring divider keeps its remainder below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < den_q))
    else $error("divider remainder out of range");

  // a measured column always holds min <= max
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EXEC) && rd_vld_q) |-> (rd_data_q.col_min <= rd_data_q.col_max))
    else $error("column min above max");

  // a measure write marks its column valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> vld_q[addr_q])
    else $error("column valid bit not set after write");
`endif

endmodule
